// ----- rtl/ist_pkg.sv -----
package ist_pkg;

    // Set size and derived widths.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths fixed by the interface.
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Request codes. The unused code behaves as a query.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

endpackage

// ----- rtl/integer_set_table.sv -----
// Each request passes S_SCAN, which reads the value memory one entry per cycle
// through its single read port, S_WRITE, which writes back, and S_HOLD, which
// loads the output register once it is free; a new request is taken only in
// S_IDLE, after the result of the last one has been loaded.
// Reset (i_rst_n low, synchronous) empties the set: valid bits and counts clear.
// Stored values are not cleared; only entries marked valid are ever compared.
module integer_set_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ist_pkg::FUNC_W-1:0]    i_func,
    input  logic signed [ist_pkg::VALUE_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ist_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_found,
    output logic [ist_pkg::COUNT_W-1:0]   o_member_count,
    output logic [ist_pkg::COUNT_W-1:0]   o_even_members
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_HOLD
    } t_state;

    localparam logic [ist_pkg::IDX_W-1:0] LAST_IDX = ist_pkg::IDX_W'(ist_pkg::CAPACITY - 1);

    // Value storage: one synchronous memory with a registered read port.
    logic [ist_pkg::VALUE_W-1:0] r_mem [ist_pkg::CAPACITY];
    logic [ist_pkg::VALUE_W-1:0] r_rd_data;

    t_state                        r_state;
    logic [ist_pkg::CAPACITY-1:0]  r_valid;
    logic [ist_pkg::CNT_W-1:0]     r_elem_total;
    logic [ist_pkg::CNT_W-1:0]     r_even_total;

    // Request held for the duration of the scan.
    logic [ist_pkg::FUNC_W-1:0]    r_func;
    logic [ist_pkg::VALUE_W-1:0]   r_value;

    // Scan bookkeeping.
    logic [ist_pkg::IDX_W-1:0]     r_addr;
    logic [ist_pkg::IDX_W-1:0]     r_cmp_idx;
    logic                          r_cmp_vld;
    logic                          r_hit;
    logic [ist_pkg::IDX_W-1:0]     r_hit_idx;
    logic                          r_free;
    logic [ist_pkg::IDX_W-1:0]     r_free_idx;

    // Result waiting for the output register.
    logic [ist_pkg::STATUS_W-1:0]  r_pend_status;
    logic                          r_pend_found;

    // Output register.
    logic                          r_out_valid;
    logic [ist_pkg::STATUS_W-1:0]  r_status;
    logic                          r_found;
    logic [ist_pkg::COUNT_W-1:0]   r_member_count;
    logic [ist_pkg::COUNT_W-1:0]   r_even_members;

    logic                          n_hit;
    logic [ist_pkg::IDX_W-1:0]     n_hit_idx;
    logic                          n_free;
    logic [ist_pkg::IDX_W-1:0]     n_free_idx;
    logic                          w_even;

    // Compare the entry read last cycle against the request value.
    always_comb begin
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        if (r_cmp_vld) begin
            if (r_valid[r_cmp_idx]) begin
                if (!r_hit && (r_rd_data == r_value)) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_cmp_idx;
                end
            end else if (!r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_cmp_idx;
            end
        end
    end

    assign w_even = ~r_value[0];

    // Memory port: one read per scan cycle, one write at write-back.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr];
        if (r_state == S_WRITE && r_func == ist_pkg::FUNC_INSERT && !n_hit && n_free) begin
            r_mem[n_free_idx] <= r_value;
        end
    end

    // Sequencer, set state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_elem_total <= '0;
            r_even_total <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // A waiting result leaves once the consumer takes it, unless a
            // new result replaces it in the same cycle.
            if (r_out_valid && i_out_ready && r_state != S_HOLD) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func    <= i_func;
                        r_value   <= i_value;
                        r_addr    <= '0;
                        r_cmp_vld <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free    <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    r_hit      <= n_hit;
                    r_hit_idx  <= n_hit_idx;
                    r_free     <= n_free;
                    r_free_idx <= n_free_idx;
                    r_cmp_vld  <= 1'b1;
                    r_cmp_idx  <= r_addr;
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end

                S_WRITE: begin
                    // Last entry is compared here; apply the operation.
                    r_cmp_vld    <= 1'b0;
                    r_pend_found <= n_hit;
                    if (r_func == ist_pkg::FUNC_INSERT) begin
                        if (n_hit) begin
                            r_pend_status <= ist_pkg::STATUS_DUP;
                        end else if (!n_free) begin
                            r_pend_status <= ist_pkg::STATUS_FULL;
                        end else begin
                            r_pend_status <= ist_pkg::STATUS_OK;
                            r_valid[n_free_idx] <= 1'b1;
                            r_elem_total <= r_elem_total + 1'b1;
                            if (w_even) begin
                                r_even_total <= r_even_total + 1'b1;
                            end
                        end
                    end else if (r_func == ist_pkg::FUNC_REMOVE) begin
                        if (!n_hit) begin
                            r_pend_status <= ist_pkg::STATUS_ABSENT;
                        end else begin
                            r_pend_status <= ist_pkg::STATUS_OK;
                            r_valid[n_hit_idx] <= 1'b0;
                            if (r_elem_total != '0) begin
                                r_elem_total <= r_elem_total - 1'b1;
                            end
                            if (w_even && r_even_total != '0) begin
                                r_even_total <= r_even_total - 1'b1;
                            end
                        end
                    end else begin
                        r_pend_status <= ist_pkg::STATUS_OK;
                    end
                    r_state <= S_HOLD;
                end

                S_HOLD: begin
                    // Load the output register once it is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_status       <= r_pend_status;
                        r_found        <= r_pend_found;
                        r_member_count <= ist_pkg::COUNT_W'(r_elem_total);
                        r_even_members <= ist_pkg::COUNT_W'(r_even_total);
                        r_state        <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_member_count = r_member_count;
    assign o_even_members = r_even_members;

endmodule

// ----- verif/set_table_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of integer_set_table, keeps its own copy of the set,
// and checks every result transfer against the oldest outstanding prediction.
module set_table_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [ist_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [ist_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [ist_pkg::STATUS_W-1:0]        i_status,
    input  logic                                i_found,
    input  logic [ist_pkg::COUNT_W-1:0]         i_member_count,
    input  logic [ist_pkg::COUNT_W-1:0]         i_even_members,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);

    typedef struct packed {
        logic [ist_pkg::STATUS_W-1:0] status;
        logic                         found;
        logic [ist_pkg::COUNT_W-1:0]  member_count;
        logic [ist_pkg::COUNT_W-1:0]  even_members;
    } t_set_result;

    // Shadow copy of the set.
    logic [ist_pkg::VALUE_W-1:0] stored_value [ist_pkg::CAPACITY];
    logic                        slot_used    [ist_pkg::CAPACITY];
    int                          population;
    int                          even_population;

    // Results predicted for accepted requests, oldest first.
    t_set_result                 result_q [$];

    function automatic void clear_set();
        int i;
        for (i = 0; i < ist_pkg::CAPACITY; i++) begin
            stored_value[i] = '0;
            slot_used[i]    = 1'b0;
        end
        population      = 0;
        even_population = 0;
    endfunction

    // Applies one request to the shadow set and returns the result it should give.
    function automatic t_set_result apply_request(logic [ist_pkg::FUNC_W-1:0] func,
                                                  logic [ist_pkg::VALUE_W-1:0] value);
        t_set_result r;
        int          hit;
        int          free_slot;
        int          i;
        hit       = -1;
        free_slot = -1;
        r.status  = ist_pkg::STATUS_OK;
        for (i = 0; i < ist_pkg::CAPACITY; i++) begin
            if (slot_used[i]) begin
                if (hit < 0 && stored_value[i] == value)
                    hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end

        if (func == ist_pkg::FUNC_INSERT) begin
            // A duplicate wins over a full set.
            if (hit >= 0) begin
                r.status = ist_pkg::STATUS_DUP;
            end else if (free_slot < 0) begin
                r.status = ist_pkg::STATUS_FULL;
            end else begin
                stored_value[free_slot] = value;
                slot_used[free_slot]    = 1'b1;
                population++;
                if (!value[0])
                    even_population++;
            end
        end else if (func == ist_pkg::FUNC_REMOVE) begin
            if (hit < 0) begin
                r.status = ist_pkg::STATUS_ABSENT;
            end else begin
                slot_used[hit] = 1'b0;
                if (population > 0)
                    population--;
                if (!value[0] && even_population > 0)
                    even_population--;
            end
        end
        // Query and the unused code leave the set alone.

        r.found        = (hit >= 0);
        r.member_count = ist_pkg::COUNT_W'(population);
        r.even_members = ist_pkg::COUNT_W'(even_population);
        return r;
    endfunction

    // Reports one field and returns 1 on a mismatch.
    function automatic int field_differs(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            return 1;
        end
        return 0;
    endfunction

    initial begin
        clear_set();
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // Result transfers are checked before request transfers of the same edge
    // are predicted, so a result never meets its own request's prediction.
    always @(posedge i_clk) begin
        t_set_result want;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            clear_set();
            result_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    errs++;
                end else begin
                    want = result_q.pop_front();
                    errs += field_differs("status", want.status, i_status);
                    errs += field_differs("found", want.found, i_found);
                    errs += field_differs("member_count", want.member_count,
                                          i_member_count);
                    errs += field_differs("even_members", want.even_members,
                                          i_even_members);
                end
            end
            if (i_in_valid && i_in_ready)
                result_q = {result_q, apply_request(i_func, i_value)};
        end
        o_fail_count  <= o_fail_count + errs;
        o_outstanding <= result_q.size();
    end

endmodule

// ----- verif/tb_integer_set_table.sv -----
`timescale 1ns / 1ps

module tb_integer_set_table;

    localparam int RANDOM_REQUESTS = 1150;
    localparam int POOL_SIZE       = 24;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 4 * (ist_pkg::CAPACITY + 3);

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic [ist_pkg::FUNC_W-1:0]         i_func;
    logic signed [ist_pkg::VALUE_W-1:0] i_value;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic [ist_pkg::STATUS_W-1:0]       o_status;
    logic                               o_found;
    logic [ist_pkg::COUNT_W-1:0]        o_member_count;
    logic [ist_pkg::COUNT_W-1:0]        o_even_members;

    int                                 check_failures;
    int                                 results_pending;
    int                                 cycle_count;
    int                                 burst_left;
    logic [ist_pkg::VALUE_W-1:0]        value_pool [POOL_SIZE];

    integer_set_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_member_count (o_member_count),
        .o_even_members (o_even_members)
    );

    set_table_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_found        (o_found),
        .i_member_count (o_member_count),
        .i_even_members (o_even_members),
        .o_fail_count   (check_failures),
        .o_outstanding  (results_pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: i_out_ready follows one of four stall patterns, drawn anew at random.
    initial begin
        int stall_mode;
        int phase;
        i_out_ready = 1'b0;
        stall_mode  = 0;
        phase       = 0;
        forever begin
            @(negedge i_clk);
            if (phase % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            phase++;
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 1);
                2: i_out_ready <= ($urandom_range(0, 7) == 0);
                default: i_out_ready <= ((phase / 5) % 2 == 0);
            endcase
        end
    end

    // Presents one request and holds it until the transfer happens. Requests
    // come in bursts separated by idle gaps of random length.
    task automatic send_request(input logic [ist_pkg::FUNC_W-1:0] func,
                                input logic [ist_pkg::VALUE_W-1:0] value);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_value    <= value;
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    // Mostly values from a small pool so that inserts collide and removes hit.
    function automatic logic [ist_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (sel < 90)
            return $urandom;
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: return 32'h0000_0002;
        endcase
    endfunction

    // Picks an operation according to the current mix.
    function automatic logic [ist_pkg::FUNC_W-1:0] pick_func(int mix);
        int roll;
        int insert_pct;
        int remove_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            0: begin insert_pct = 65; remove_pct = 15; end
            1: begin insert_pct = 20; remove_pct = 60; end
            default: begin insert_pct = 35; remove_pct = 35; end
        endcase
        if (roll < insert_pct)
            return ist_pkg::FUNC_INSERT;
        if (roll < insert_pct + remove_pct)
            return ist_pkg::FUNC_REMOVE;
        if (roll < 95)
            return ist_pkg::FUNC_QUERY;
        return ist_pkg::FUNC_UNUSED;
    endfunction

    // Stimulus and verdict.
    initial begin
        int mix;
        int n;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_func     = ist_pkg::FUNC_INSERT;
        i_value    = '0;
        burst_left = 0;
        mix        = 2;
        for (n = 0; n < POOL_SIZE; n++)
            value_pool[n] = $urandom;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, duplicates, absent values, the unused code,
        // filling the set, a full set and a duplicate on a full set.
        send_request(ist_pkg::FUNC_INSERT, 32'h0000_0000);
        send_request(ist_pkg::FUNC_INSERT, 32'h8000_0000);
        send_request(ist_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
        send_request(ist_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
        send_request(ist_pkg::FUNC_INSERT, 32'h0000_0000);
        send_request(ist_pkg::FUNC_QUERY,  32'h0000_0000);
        send_request(ist_pkg::FUNC_QUERY,  32'h0000_0001);
        send_request(ist_pkg::FUNC_UNUSED, 32'hFFFF_FFFF);
        send_request(ist_pkg::FUNC_REMOVE, 32'h7FFF_FFFF);
        send_request(ist_pkg::FUNC_REMOVE, 32'h7FFF_FFFF);
        for (n = 0; n < ist_pkg::CAPACITY - 3; n++)
            send_request(ist_pkg::FUNC_INSERT, ist_pkg::VALUE_W'(100 + 7 * n));
        send_request(ist_pkg::FUNC_INSERT, 32'd999);
        send_request(ist_pkg::FUNC_INSERT, 32'd100);
        send_request(ist_pkg::FUNC_REMOVE, 32'h8000_0000);

        // Random: the operation mix shifts so the set fills and drains repeatedly.
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 120 == 0)
                mix = $urandom_range(0, 2);
            if (n % 40 == 0)
                value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            send_request(pick_func(mix), pick_value());
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (check_failures == 0 && results_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
